// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. They compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: %m");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: %m");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/pfpm_pkg.sv =====
// ----------------------------------------------------------------------------
// Pulse frequency power meter package
// Shared widths, event kinds and controller/datapath interface types.
// ----------------------------------------------------------------------------
package pfpm_pkg;

    localparam int FRACTION_BITS = 8;
    localparam int TIME_W        = 32;
    localparam int SUM_W         = 40;
    localparam int COUNT_W       = 32;
    localparam int VALUE_W       = 48;
    localparam int INTERVAL_W    = 24;
    localparam int KIND_W        = 3;
    localparam int CFG_INDEX_W   = 2;
    localparam int US_W          = 20;
    localparam int NUM_W         = COUNT_W + US_W;
    localparam int SAT_SHIFT     = VALUE_W - FRACTION_BITS;
    localparam int DIV_STEPS     = VALUE_W;
    localparam int STEP_W        = $clog2(DIV_STEPS);
    localparam int OUT_DATA_W    = ((VALUE_W + 2 + 7) / 8) * 8;

    localparam logic [US_W-1:0]       US_PER_S          = US_W'(1000000);
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET    = INTERVAL_W'(500000);

    typedef enum logic [KIND_W-1:0] {
        KIND_POWER_EDGE   = 3'd0,
        KIND_SHARED_EDGE  = 3'd1,
        KIND_READ_POWER   = 3'd2,
        KIND_READ_ENERGY  = 3'd3,
        KIND_READ_CURRENT = 3'd4,
        KIND_READ_VOLTAGE = 3'd5
    } kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ENABLE       = 2'd0,
        CFG_CURRENT_SEL  = 2'd1,
        CFG_INTERVAL     = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic                  enable;
        logic                  current_select_level;
        logic [INTERVAL_W-1:0] switch_interval_us;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic check;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic rate_read;
        logic trivial;
        logic out_valid;
    } status_t;

endpackage

// ===== rtl/pfpm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Pulse frequency power meter controller
// Sequences accept, execute, divider iterations and result hand-off.
// ----------------------------------------------------------------------------
module pfpm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              m_tready,
    input  pfpm_pkg::status_t status,
    output pfpm_pkg::cmd_t    cmd
);
    import pfpm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CHECK,
        S_DIV,
        S_DONE
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic                out_free;

    assign out_free = !status.out_valid || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = status.rate_read ? S_CHECK : S_DONE;
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                step_next  = '0;
                state_next = status.trivial ? S_DONE : S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ===== rtl/pfpm_datapath.sv =====
// ----------------------------------------------------------------------------
// Pulse frequency power meter datapath
// Window accumulators, mode switching, rate multiplier, restoring divider
// and the output register.
// ----------------------------------------------------------------------------
module pfpm_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pfpm_pkg::cfg_t                 cfg,
    input  pfpm_pkg::cmd_t                 cmd,
    output pfpm_pkg::status_t              status,
    input  logic [pfpm_pkg::KIND_W-1:0]    in_kind,
    input  logic [pfpm_pkg::TIME_W-1:0]    in_time,
    input  logic                           m_tready,
    output logic                           m_tvalid,
    output logic [pfpm_pkg::VALUE_W-1:0]   out_value,
    output logic                           out_select_level,
    output logic                           out_mode_switched
);
    import pfpm_pkg::*;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] sum,
                                                 input logic [TIME_W-1:0] period);
        logic [SUM_W:0] total;
        total = {1'b0, sum} + (SUM_W + 1)'(period);
        return total[SUM_W] ? '1 : total[SUM_W-1:0];
    endfunction

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] count);
        return (count == '1) ? count : count + 1'b1;
    endfunction

    kind_t               kind_reg;
    logic [TIME_W-1:0]   time_reg;
    logic [TIME_W-1:0]   last_power_reg;
    logic [TIME_W-1:0]   last_shared_reg;
    logic [TIME_W-1:0]   last_switch_reg;
    logic [SUM_W-1:0]    p_sum_reg;
    logic [COUNT_W-1:0]  p_cnt_reg;
    logic [VALUE_W-1:0]  p_total_reg;
    logic [SUM_W-1:0]    c_sum_reg;
    logic [COUNT_W-1:0]  c_cnt_reg;
    logic [SUM_W-1:0]    v_sum_reg;
    logic [COUNT_W-1:0]  v_cnt_reg;
    logic                meas_v_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [SUM_W-1:0]    divisor_reg;
    logic                cnt_nz_reg;
    logic [SUM_W-1:0]    rem_reg;
    logic [VALUE_W-1:0]  quo_reg;
    logic                use_quo_reg;
    logic [VALUE_W-1:0]  result_reg;
    logic                switched_reg;
    logic                m_valid_reg;
    logic [VALUE_W-1:0]  m_value_reg;
    logic                m_select_reg;
    logic                m_switched_reg;

    logic [TIME_W-1:0]   power_period;
    logic [TIME_W-1:0]   shared_period;
    logic [TIME_W-1:0]   switch_elapsed;
    logic                switch_due;
    logic [SUM_W-1:0]    rate_sum;
    logic [COUNT_W-1:0]  rate_cnt;
    logic                saturate;
    logic [SUM_W:0]      trial;
    logic [SUM_W:0]      diff;
    logic                trial_ge;
    logic [SUM_W-1:0]    rem_next;
    logic [VALUE_W-1:0]  quo_next;

    assign power_period   = time_reg - last_power_reg;
    assign shared_period  = time_reg - last_shared_reg;
    assign switch_elapsed = time_reg - last_switch_reg;
    assign switch_due     = switch_elapsed > TIME_W'(cfg.switch_interval_us);

    always_comb
    begin
        case (kind_reg)
            KIND_READ_POWER:
            begin
                rate_sum = p_sum_reg;
                rate_cnt = p_cnt_reg;
            end
            KIND_READ_CURRENT:
            begin
                rate_sum = c_sum_reg;
                rate_cnt = c_cnt_reg;
            end
            KIND_READ_VOLTAGE:
            begin
                rate_sum = v_sum_reg;
                rate_cnt = v_cnt_reg;
            end
            default:
            begin
                rate_sum = '0;
                rate_cnt = '0;
            end
        endcase
    end

    assign saturate = (num_reg >> SAT_SHIFT) >= NUM_W'(divisor_reg);

    assign trial    = {rem_reg, quo_reg[VALUE_W-1]};
    assign diff     = trial - {1'b0, divisor_reg};
    assign trial_ge = trial >= {1'b0, divisor_reg};
    assign rem_next = trial_ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
    assign quo_next = {quo_reg[VALUE_W-2:0], trial_ge};

    assign status.rate_read = (kind_reg inside {KIND_READ_POWER, KIND_READ_CURRENT,
                                                KIND_READ_VOLTAGE});
    assign status.trivial   = !cnt_nz_reg || (divisor_reg == '0) || saturate;
    assign status.out_valid = m_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_power_reg  <= '0;
            last_shared_reg <= '0;
            last_switch_reg <= '0;
            p_sum_reg       <= '0;
            p_cnt_reg       <= '0;
            p_total_reg     <= '0;
            c_sum_reg       <= '0;
            c_cnt_reg       <= '0;
            v_sum_reg       <= '0;
            v_cnt_reg       <= '0;
            meas_v_reg      <= 1'b0;
        end
        else if (cmd.exec)
        begin
            case (kind_reg)
                KIND_POWER_EDGE:
                begin
                    if (cfg.enable)
                    begin
                        p_sum_reg      <= sat_add(p_sum_reg, power_period);
                        p_cnt_reg      <= sat_inc(p_cnt_reg);
                        p_total_reg    <= p_total_reg + 1'b1;
                        last_power_reg <= time_reg;
                    end
                end
                KIND_SHARED_EDGE:
                begin
                    if (cfg.enable)
                    begin
                        if (meas_v_reg)
                        begin
                            v_sum_reg <= sat_add(v_sum_reg, shared_period);
                            v_cnt_reg <= sat_inc(v_cnt_reg);
                        end
                        else
                        begin
                            c_sum_reg <= sat_add(c_sum_reg, shared_period);
                            c_cnt_reg <= sat_inc(c_cnt_reg);
                        end
                        last_shared_reg <= time_reg;
                        if (switch_due)
                        begin
                            last_switch_reg <= time_reg;
                            meas_v_reg      <= !meas_v_reg;
                        end
                    end
                end
                KIND_READ_POWER:
                begin
                    p_sum_reg <= '0;
                    p_cnt_reg <= '0;
                end
                KIND_READ_CURRENT:
                begin
                    c_sum_reg <= '0;
                    c_cnt_reg <= '0;
                end
                KIND_READ_VOLTAGE:
                begin
                    v_sum_reg <= '0;
                    v_cnt_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Working registers of one item; they carry no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind_t'(in_kind);
            time_reg <= in_time;
        end
        if (cmd.exec)
        begin
            num_reg      <= NUM_W'(rate_cnt) * NUM_W'(US_PER_S);
            divisor_reg  <= rate_sum;
            cnt_nz_reg   <= (rate_cnt != '0);
            use_quo_reg  <= 1'b0;
            switched_reg <= (kind_reg == KIND_SHARED_EDGE) && cfg.enable && switch_due;
            result_reg   <= (kind_reg == KIND_READ_ENERGY) ? p_total_reg : '0;
        end
        if (cmd.check)
        begin
            rem_reg     <= SUM_W'(num_reg >> SAT_SHIFT);
            quo_reg     <= VALUE_W'(num_reg << FRACTION_BITS);
            use_quo_reg <= !status.trivial;
            result_reg  <= (cnt_nz_reg && (divisor_reg != '0) && saturate) ? '1 : '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (cmd.out_load)
        begin
            m_value_reg    <= use_quo_reg ? quo_reg : result_reg;
            m_select_reg   <= meas_v_reg ^ cfg.current_select_level;
            m_switched_reg <= switched_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid          = m_valid_reg;
    assign out_value         = m_value_reg;
    assign out_select_level  = m_select_reg;
    assign out_mode_switched = m_switched_reg;

endmodule

// ===== rtl/pulse_frequency_power_meter.sv =====
// ----------------------------------------------------------------------------
// Pulse frequency power meter
// Edge timing, window rates and pulse totals for an energy-meter chip.
// ----------------------------------------------------------------------------
// Edges, energy reads and unused kinds: the input transaction is registered,
// executed and loaded into the output register; no new one is taken till then.
// Rate reads: the result is set by the 48-step restoring divider; an empty or
// saturating window skips the divider.
// Reset clears all windows, totals and timestamps, selects current mode,
// disables edges and loads a switch interval of 500000 us.
module pulse_frequency_power_meter (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // time_us[31:0]
    input  logic [pfpm_pkg::TIME_W-1:0]              s_tdata,
    // kind[2:0]
    input  logic [pfpm_pkg::KIND_W-1:0]              s_tuser,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // value[47:0], select_level[48], mode_switched[49], zero pad[55:50]
    output logic [pfpm_pkg::OUT_DATA_W-1:0]          m_tdata,
    input  logic                                     cfg_we,
    input  logic [pfpm_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [pfpm_pkg::INTERVAL_W-1:0]          cfg_data
);
    import pfpm_pkg::*;

`include "assert_macros.svh"

    cfg_t                cfg_reg;
    cmd_t                cmd;
    status_t             status;
    logic [VALUE_W-1:0]  out_value;
    logic                out_select_level;
    logic                out_mode_switched;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable               <= 1'b0;
            cfg_reg.current_select_level <= 1'b0;
            cfg_reg.switch_interval_us   <= INTERVAL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENABLE:      cfg_reg.enable               <= cfg_data[0];
                CFG_CURRENT_SEL: cfg_reg.current_select_level <= cfg_data[0];
                CFG_INTERVAL:    cfg_reg.switch_interval_us   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    pfpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pfpm_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg_reg),
        .cmd               (cmd),
        .status            (status),
        .in_kind           (s_tuser),
        .in_time           (s_tdata),
        .m_tready          (m_tready),
        .m_tvalid          (m_tvalid),
        .out_value         (out_value),
        .out_select_level  (out_select_level),
        .out_mode_switched (out_mode_switched)
    );

    assign m_tdata = OUT_DATA_W'({out_mode_switched, out_select_level, out_value});

    // One transaction is in flight at a time.
    `ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_tvalid && s_tready, !s_tready)
    // A mode flip only comes from an edge, whose value is zero.
    `ASSERT_IMPLIES(a_switch_zero_value, clk, rst_n, m_tvalid && m_tdata[VALUE_W + 1],
                    m_tdata[VALUE_W-1:0] == '0)
    // A new result is only loaded while the controller holds off input.
    `ASSERT_IMPLIES(a_result_from_done, clk, rst_n, $rose(m_tvalid), $past(!s_tready))

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Pulse frequency power meter testbench
// Drives edge, read and spare transactions into the meter and checks each result
// against a typed value or a cycle-free model of windows, totals and mode flips.
// A short scripted sequence covers reset values, timestamp wrap, empty
// windows, disabled edges and the interval extremes. Random phases then
// run under several register settings, with random gaps on both streams
// and one long output stall that backs the block up.
// ----------------------------------------------------------------------------
module tb_top;
    import pfpm_pkg::*;

    localparam logic [KIND_W-1:0]  KIND_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0]  KIND_SPARE_HI = 3'd7;
    localparam logic [SUM_W-1:0]   SUM_CAP       = '1;
    localparam logic [COUNT_W-1:0] COUNT_CAP     = '1;
    localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = '1;
    localparam int unsigned CYCLE_LIMIT  = 2000000;
    localparam int unsigned LONG_HOLD    = 400;
    localparam int unsigned DRAIN_CYCLES = 80;
    localparam int unsigned REPORT_MAX   = 10;
    localparam int unsigned NUM_PHASES   = 7;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               select_level;
        logic               mode_switched;
    } meter_result_t;

    typedef struct {
        bit                    is_write;
        cfg_index_t            reg_idx;
        logic [INTERVAL_W-1:0] wdata;
        logic [KIND_W-1:0]     kind;
        logic [TIME_W-1:0]     stamp;
        bit                    typed;
        meter_result_t         typed_res;
    } script_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TIME_W-1:0]      s_tdata;
    logic [KIND_W-1:0]      s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [INTERVAL_W-1:0]  cfg_data;

    // Model state, reset values as after rst_n.
    logic                  meter_on      = 1'b0;
    logic                  cur_sel_level = 1'b0;
    logic [INTERVAL_W-1:0] flip_interval = INTERVAL_RESET;
    logic [TIME_W-1:0]     pwr_last_t    = '0;
    logic [TIME_W-1:0]     shr_last_t    = '0;
    logic [TIME_W-1:0]     flip_last_t   = '0;
    logic [SUM_W-1:0]      pwr_sum       = '0;
    logic [COUNT_W-1:0]    pwr_cnt       = '0;
    logic [VALUE_W-1:0]    pwr_total     = '0;
    logic [SUM_W-1:0]      cur_sum       = '0;
    logic [COUNT_W-1:0]    cur_cnt       = '0;
    logic [SUM_W-1:0]      volt_sum      = '0;
    logic [COUNT_W-1:0]    volt_cnt      = '0;
    logic                  volt_mode     = 1'b0;

    meter_result_t expected_results[$];
    script_row_t   script[$];

    logic [TIME_W-1:0] now_us;
    bit                steady;
    int unsigned       items_in;
    int unsigned       rate_reads;
    int unsigned       flips_seen;
    int unsigned       results_seen = 0;
    int unsigned       fail_count = 0;
    int unsigned       settings_tried;
    int unsigned       cycle_count = 0;

    pulse_frequency_power_meter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic void add_window(inout logic [SUM_W-1:0] sum,
                                       inout logic [COUNT_W-1:0] cnt,
                                       input logic [TIME_W-1:0] period);
        logic [SUM_W:0] total;
        total = {1'b0, sum} + {{(SUM_W + 1 - TIME_W){1'b0}}, period};
        sum = total[SUM_W] ? SUM_CAP : total[SUM_W-1:0];
        if (cnt != COUNT_CAP)
            cnt = cnt + 1'b1;
    endfunction

    function automatic logic [VALUE_W-1:0] window_rate(input logic [SUM_W-1:0] sum,
                                                       input logic [COUNT_W-1:0] cnt);
        logic [63:0] num;
        logic [63:0] quo;
        logic [63:0] rem;
        logic [63:0] rate;
        if (cnt == '0 || sum == '0)
            return '0;
        num = 64'(cnt) * 64'd1000000;
        quo = num / 64'(sum);
        rem = num % 64'(sum);
        if (quo >= (64'd1 << SAT_SHIFT))
            return '1;
        rate = (quo << FRACTION_BITS) + ((rem << FRACTION_BITS) / 64'(sum));
        if (rate[63:VALUE_W] != '0)
            return '1;
        return rate[VALUE_W-1:0];
    endfunction

    function automatic meter_result_t meter_step(input logic [KIND_W-1:0] k,
                                                 input logic [TIME_W-1:0] t);
        meter_result_t     res;
        logic [TIME_W-1:0] elapsed;
        res = '0;
        case (k)
            KIND_POWER_EDGE:
            begin
                if (meter_on)
                begin
                    add_window(pwr_sum, pwr_cnt, t - pwr_last_t);
                    pwr_total = pwr_total + 1'b1;
                    pwr_last_t = t;
                end
            end
            KIND_SHARED_EDGE:
            begin
                if (meter_on)
                begin
                    if (volt_mode)
                        add_window(volt_sum, volt_cnt, t - shr_last_t);
                    else
                        add_window(cur_sum, cur_cnt, t - shr_last_t);
                    shr_last_t = t;
                    elapsed = t - flip_last_t;
                    if (elapsed > TIME_W'(flip_interval))
                    begin
                        flip_last_t = t;
                        volt_mode = ~volt_mode;
                        res.mode_switched = 1'b1;
                    end
                end
            end
            KIND_READ_POWER:
            begin
                res.value = window_rate(pwr_sum, pwr_cnt);
                pwr_sum = '0;
                pwr_cnt = '0;
            end
            KIND_READ_ENERGY:
                res.value = pwr_total;
            KIND_READ_CURRENT:
            begin
                res.value = window_rate(cur_sum, cur_cnt);
                cur_sum = '0;
                cur_cnt = '0;
            end
            KIND_READ_VOLTAGE:
            begin
                res.value = window_rate(volt_sum, volt_cnt);
                volt_sum = '0;
                volt_cnt = '0;
            end
            default: ;
        endcase
        res.select_level = volt_mode ^ cur_sel_level;
        return res;
    endfunction

    function automatic int unsigned idle_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [TIME_W-1:0] step_us();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(0, 40000000);
        return $urandom_range(100, 30000);
    endfunction

    function automatic void push_item(input logic [KIND_W-1:0] k, input logic [TIME_W-1:0] t);
        script_row_t row;
        row = '{is_write: 1'b0, reg_idx: CFG_ENABLE, wdata: '0, kind: k, stamp: t,
                typed: 1'b0, typed_res: '0};
        script.push_back(row);
    endfunction

    function automatic void push_check(input logic [KIND_W-1:0] k, input logic [TIME_W-1:0] t,
                                       input logic [VALUE_W-1:0] v, input logic sel);
        script_row_t row;
        row = '{is_write: 1'b0, reg_idx: CFG_ENABLE, wdata: '0, kind: k, stamp: t,
                typed: 1'b1, typed_res: '{value: v, select_level: sel, mode_switched: 1'b0}};
        script.push_back(row);
    endfunction

    function automatic void push_write(input cfg_index_t idx, input logic [INTERVAL_W-1:0] val);
        script_row_t row;
        row = '{is_write: 1'b1, reg_idx: idx, wdata: val, kind: '0, stamp: '0,
                typed: 1'b0, typed_res: '0};
        script.push_back(row);
    endfunction

    function automatic void report_mismatch(input string why, input meter_result_t want,
                                            input meter_result_t got);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("%s: expected value=%h select=%b switched=%b, got value=%h select=%b switched=%b",
                     why, want.value, want.select_level, want.mode_switched,
                     got.value, got.select_level, got.mode_switched);
    endfunction

    task automatic issue(input logic [KIND_W-1:0] k, input logic [TIME_W-1:0] t,
                         input bit typed, input meter_result_t typed_res);
        meter_result_t predicted;
        int unsigned   gap;
        bit            ignored;
        s_tvalid <= 1'b1;
        s_tdata  <= t;
        s_tuser  <= k;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        ignored = (k > KIND_READ_VOLTAGE) ||
                  (!meter_on && (k == KIND_POWER_EDGE || k == KIND_SHARED_EDGE));
        predicted = meter_step(k, t);
        expected_results.push_back(typed ? typed_res : predicted);
        if (!ignored)
            items_in++;
        if (k == KIND_READ_POWER || k == KIND_READ_CURRENT || k == KIND_READ_VOLTAGE)
            rate_reads++;
        if (predicted.mode_switched)
            flips_seen++;
        gap = steady ? 0 : idle_len();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [INTERVAL_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_ENABLE:      meter_on = val[0];
            CFG_CURRENT_SEL: cur_sel_level = val[0];
            CFG_INTERVAL:    flip_interval = val;
            default: ;
        endcase
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("pulse_frequency_power_meter: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
    begin : result_check
        meter_result_t got;
        meter_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.value         = m_tdata[VALUE_W-1:0];
            got.select_level  = m_tdata[VALUE_W];
            got.mode_switched = m_tdata[VALUE_W+1];
            results_seen++;
            if (expected_results.size() == 0)
                report_mismatch("result with no transaction outstanding", '0, got);
            else
            begin
                want = expected_results.pop_front();
                if (got.value !== want.value || got.select_level !== want.select_level ||
                    got.mode_switched !== want.mode_switched)
                    report_mismatch("result mismatch", want, got);
            end
        end
    end

    initial
    begin : sink_side
        int unsigned stall;
        int unsigned open_len;
        bit          held;
        held = 1'b0;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            // One long stall so the block backs up onto its input.
            if (!held && results_seen >= 300)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            stall = idle_len();
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            open_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 6);
            m_tready <= 1'b1;
            repeat (open_len) @(posedge clk);
        end
    end

    initial
    begin : source_side
        int unsigned       phase;
        int unsigned       target;
        int unsigned       start;
        int unsigned       roll;
        logic              ph_en;
        logic              ph_sel;
        logic [INTERVAL_W-1:0] ph_interval;
        logic [KIND_W-1:0] k;
        logic [TIME_W-1:0] t;
        items_in       = 0;
        rate_reads     = 0;
        flips_seen     = 0;
        settings_tried = 0;
        steady         = 1'b0;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;

        push_check(KIND_READ_ENERGY, 32'h0000_0000, '0, 1'b0);
        push_check(KIND_READ_POWER, 32'hFFFF_FFFF, '0, 1'b0);
        push_check(KIND_POWER_EDGE, 32'd1000, '0, 1'b0);
        push_check(KIND_SHARED_EDGE, 32'hFFFF_FFFF, '0, 1'b0);
        push_check(KIND_SPARE_LO, 32'h0000_0000, '0, 1'b0);
        push_check(KIND_SPARE_HI, 32'hFFFF_FFFF, '0, 1'b0);
        push_check(KIND_READ_CURRENT, 32'h5555_5555, '0, 1'b0);
        push_check(KIND_READ_VOLTAGE, 32'hAAAA_AAAA, '0, 1'b0);
        push_write(CFG_ENABLE, 24'd1);
        push_write(CFG_CURRENT_SEL, 24'd1);
        push_check(KIND_POWER_EDGE, 32'd0, '0, 1'b1);
        push_check(KIND_READ_POWER, 32'd0, '0, 1'b1);
        push_item(KIND_POWER_EDGE, 32'hFFFF_FFF0);
        push_item(KIND_POWER_EDGE, 32'd10);
        push_item(KIND_READ_POWER, 32'd0);
        push_item(KIND_READ_ENERGY, 32'd0);
        push_item(KIND_SHARED_EDGE, 32'd250000);
        push_item(KIND_SHARED_EDGE, 32'd750001);
        push_item(KIND_READ_CURRENT, 32'd0);
        push_check(KIND_READ_VOLTAGE, 32'd0, '0, 1'b0);
        push_write(CFG_INTERVAL, 24'd0);
        push_item(KIND_SHARED_EDGE, 32'd750001);
        push_item(KIND_SHARED_EDGE, 32'd750002);
        push_item(KIND_READ_VOLTAGE, 32'd0);
        push_write(CFG_INTERVAL, INTERVAL_MAX);
        push_item(KIND_SHARED_EDGE, 32'd750002 + 32'd16777215);
        push_item(KIND_SHARED_EDGE, 32'd750002 + 32'd16777216);
        push_item(KIND_READ_CURRENT, 32'd0);
        push_write(CFG_CURRENT_SEL, 24'd0);
        push_item(KIND_SPARE_HI, 32'd12345);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].is_write)
            begin
                settle();
                write_reg(script[i].reg_idx, script[i].wdata);
            end
            else
                issue(script[i].kind, script[i].stamp, script[i].typed, script[i].typed_res);
        end
        settings_tried = 4;

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            ph_en = 1'b1;
            ph_sel = 1'b0;
            ph_interval = INTERVAL_RESET;
            target = 300;
            case (phase)
                0: ph_interval = INTERVAL_W'($urandom_range(2000, 100000));
                1:
                begin
                    ph_sel = 1'b1;
                    ph_interval = 24'd1;
                end
                2:
                begin
                    ph_en = 1'b0;
                    ph_sel = 1'b1;
                    target = 15;
                end
                3:
                begin
                    ph_interval = INTERVAL_MAX;
                    target = 280;
                end
                4:
                begin
                    ph_sel = 1'b1;
                    ph_interval = 24'd0;
                    target = 280;
                end
                6:
                begin
                    ph_sel = 1'($urandom_range(0, 1));
                    ph_interval = INTERVAL_W'($urandom_range(1, 16777215));
                    target = 350;
                end
                default: ;
            endcase
            settle();
            write_reg(CFG_ENABLE, {23'd0, ph_en});
            write_reg(CFG_CURRENT_SEL, {23'd0, ph_sel});
            write_reg(CFG_INTERVAL, ph_interval);
            settings_tried++;
            now_us = $urandom_range(0, 1) ? 32'($urandom) :
                     32'hFFFF_FFFF - 32'($urandom_range(0, 3000000));
            start = items_in;

            // Many edges on one timestamp: a window with pulses but no elapsed time,
            // then a single microsecond of elapsed time for a very high rate.
            if (phase == 1)
            begin
                issue(KIND_POWER_EDGE, now_us, 1'b0, '0);
                issue(KIND_READ_POWER, now_us, 1'b0, '0);
                repeat (30) issue(KIND_POWER_EDGE, now_us, 1'b0, '0);
                issue(KIND_READ_POWER, now_us, 1'b0, '0);
                repeat (30) issue(KIND_POWER_EDGE, now_us, 1'b0, '0);
                issue(KIND_POWER_EDGE, now_us + 1'b1, 1'b0, '0);
                issue(KIND_READ_POWER, now_us, 1'b0, '0);
                now_us = now_us + 1'b1;
            end

            // Periods of one microsecond short of a full wrap push the sum to its cap.
            if (phase == 5)
            begin
                issue(KIND_POWER_EDGE, now_us, 1'b0, '0);
                for (int i = 1; i <= 260; i++)
                    issue(KIND_POWER_EDGE, now_us - TIME_W'(i), 1'b0, '0);
                issue(KIND_READ_POWER, now_us, 1'b0, '0);
                issue(KIND_READ_ENERGY, now_us, 1'b0, '0);
                now_us = now_us - 32'd260;
            end

            while (items_in - start < target)
            begin
                if ($urandom_range(0, 49) == 0)
                    steady = ($urandom_range(0, 2) == 0);
                roll = $urandom_range(0, 99);
                if (roll < 38)
                begin
                    now_us = now_us + step_us();
                    k = KIND_POWER_EDGE;
                    t = now_us;
                end
                else if (roll < 72)
                begin
                    now_us = now_us + step_us();
                    k = KIND_SHARED_EDGE;
                    t = now_us;
                end
                else if (roll < 84)
                begin
                    case ($urandom_range(0, 2))
                        0: k = KIND_READ_POWER;
                        1: k = KIND_READ_CURRENT;
                        default: k = KIND_READ_VOLTAGE;
                    endcase
                    t = $urandom;
                end
                else if (roll < 87)
                begin
                    k = KIND_READ_ENERGY;
                    t = $urandom;
                end
                else if (roll < 95)
                begin
                    k = KIND_W'($urandom_range(0, 7));
                    t = $urandom;
                end
                else if (roll < 98)
                begin
                    k = $urandom_range(0, 1) ? KIND_POWER_EDGE : KIND_SHARED_EDGE;
                    t = now_us;
                end
                else
                begin
                    k = $urandom_range(0, 1) ? KIND_POWER_EDGE : KIND_SHARED_EDGE;
                    t = now_us - 32'($urandom_range(1, 1000));
                end
                issue(k, t, 1'b0, '0);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d input transactions, %0d rate reads and %0d mode switches",
                 items_in, rate_reads, flips_seen);
        $display("across %0d register settings; %0d results compared, %0d failures.",
                 settings_tried, results_seen, fail_count);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("pulse_frequency_power_meter: match");
        else
            $display("pulse_frequency_power_meter: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pfpm_pkg.sv
rtl/pfpm_ctrl.sv
rtl/pfpm_datapath.sv
rtl/pulse_frequency_power_meter.sv
bench/tb_top.sv
